FILE: hw/rtl/v3a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_pkg
// shared types and defaults for the 3d vector arithmetic unit
// ----------------------------------------------------------------------------
package v3a_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_DOT    = 3'd2,
        OP_CROSS  = 3'd3,
        OP_SCALE  = 3'd4,
        OP_LENGTH = 3'd5,
        OP_NORM   = 3'd6
    } t_op;

endpackage

FILE: hw/rtl/v3a_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_if
// request and result channels of the vector unit, valid/ready handshake
// ----------------------------------------------------------------------------
interface v3a_req_if #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           req_type;
    logic [WORD_BITS-1:0] a_x;
    logic [WORD_BITS-1:0] a_y;
    logic [WORD_BITS-1:0] a_z;
    logic [WORD_BITS-1:0] b_x;
    logic [WORD_BITS-1:0] b_y;
    logic [WORD_BITS-1:0] b_z;
    logic [WORD_BITS-1:0] scale_factor;

    modport source (
        output valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
        input  ready
    );
    modport sink (
        input  valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
        output ready
    );
endinterface

interface v3a_rsp_if #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;
    logic [WORD_BITS-1:0] r_z;
    logic                 overflow;
    logic                 zero_length;

    modport source (
        output valid, r_x, r_y, r_z, overflow, zero_length,
        input  ready
    );
    modport sink (
        input  valid, r_x, r_y, r_z, overflow, zero_length,
        output ready
    );
endinterface

FILE: hw/rtl/v3a_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_front
// product stage and sum stage: operand selection, six multipliers, then the
// exact sums and differences, the sum of squares and the component magnitudes
// ----------------------------------------------------------------------------
module v3a_front #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_op,
    input  logic [2:0][WORD_BITS-1:0]         i_a,
    input  logic [2:0][WORD_BITS-1:0]         i_b,
    input  logic [WORD_BITS-1:0]              i_s,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_op,
    output logic [2:0][WORD_BITS-1:0]         o_mag,
    output logic [2:0]                        o_neg,
    output logic [2:0][2*WORD_BITS+2:0]       o_val,
    output logic [2*WORD_BITS-1:0]            o_rad
);
    import v3a_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS + 3;

    logic signed [W-1:0]   ma [6];
    logic signed [W-1:0]   mb [6];
    logic signed [2*W-1:0] n_p [6];
    logic signed [W:0]     n_e [3];

    logic                  r_v1;
    logic [2:0]            r_op1;
    logic [2:0][W-1:0]     r_a1;
    logic signed [2*W-1:0] r_p [6];
    logic signed [W:0]     r_e [3];

    logic signed [PW-1:0]  xp [6];
    logic signed [PW-1:0]  xe [3];
    logic signed [PW-1:0]  sq;
    logic [2:0][PW-1:0]    n_val;
    logic [2:0][W-1:0]     n_mag;
    logic [2:0]            n_neg;

    logic                  r_v2;
    logic [2:0]            r_op2;
    logic [2:0][W-1:0]     r_mag;
    logic [2:0]            r_neg;
    logic [2:0][PW-1:0]    r_val;
    logic [2*W-1:0]        r_rad;

    logic                  s1_ready;
    logic                  s2_ready;

    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;

    // operand selection for the multipliers, and the operand sums or differences
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            ma[k] = '0;
            mb[k] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (t_op'(i_op) == OP_SUB) begin
                n_e[i] = $signed({i_a[i][W-1], i_a[i]}) - $signed({i_b[i][W-1], i_b[i]});
            end else begin
                n_e[i] = $signed({i_a[i][W-1], i_a[i]}) + $signed({i_b[i][W-1], i_b[i]});
            end
        end
        unique case (t_op'(i_op))
            OP_CROSS: begin
                ma[0] = i_a[1]; mb[0] = i_b[2];
                ma[1] = i_b[1]; mb[1] = i_a[2];
                ma[2] = i_b[0]; mb[2] = i_a[2];
                ma[3] = i_a[0]; mb[3] = i_b[2];
                ma[4] = i_a[0]; mb[4] = i_b[1];
                ma[5] = i_b[0]; mb[5] = i_a[1];
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    ma[i] = i_a[i];
                    mb[i] = i_s;
                end
            end
            OP_LENGTH, OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    ma[i] = i_a[i];
                    mb[i] = i_a[i];
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    ma[i] = i_a[i];
                    mb[i] = i_b[i];
                end
            end
        endcase
        for (int k = 0; k < 6; k++) begin
            n_p[k] = ma[k] * mb[k];
        end
    end

    // sums and differences of the products and of the operands, and the component magnitudes
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            xp[k] = PW'(r_p[k]);
        end
        for (int i = 0; i < 3; i++) begin
            xe[i]    = PW'(r_e[i]);
            n_val[i] = '0;
            n_neg[i] = r_a1[i][W-1];
            n_mag[i] = r_a1[i][W-1] ? (~r_a1[i]) + W'(1) : r_a1[i];
        end
        sq = xp[0] + xp[1] + xp[2];
        unique case (t_op'(r_op1))
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    n_val[i] = xe[i];
                end
            end
            OP_DOT: begin
                n_val[0] = sq;
            end
            OP_CROSS: begin
                n_val[0] = xp[0] - xp[1];
                n_val[1] = xp[2] - xp[3];
                n_val[2] = xp[4] - xp[5];
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_val[i] = xp[i];
                end
            end
            default: begin
                n_val[0] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_op1 <= i_op;
            r_a1  <= i_a;
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= n_p[k];
            end
            for (int i = 0; i < 3; i++) begin
                r_e[i] <= n_e[i];
            end
        end
        if (s2_ready && r_v1) begin
            r_op2 <= r_op1;
            r_mag <= n_mag;
            r_neg <= n_neg;
            r_val <= n_val;
            r_rad <= sq[2*W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_op    = r_op2;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_val   = r_val;
    assign o_rad   = r_rad;

endmodule

FILE: hw/rtl/v3a_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_sqrt_cell
// one digit of the integer square root: takes two radicand bits, forms one
// root bit and hands the partial remainder and root to the next cell
// ----------------------------------------------------------------------------
module v3a_sqrt_cell #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS,
    parameter int SIDE_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2*WORD_BITS-1:0] i_rad,
    input  logic [WORD_BITS:0]     i_rem,
    input  logic [WORD_BITS-1:0]   i_root,
    input  logic [SIDE_BITS-1:0]   i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*WORD_BITS-1:0] o_rad,
    output logic [WORD_BITS:0]     o_rem,
    output logic [WORD_BITS-1:0]   o_root,
    output logic [SIDE_BITS-1:0]   o_side
);
    localparam int W = WORD_BITS;

    logic [W+2:0]     t;
    logic [W+2:0]     trial;
    logic             ge;
    logic [W+2:0]     diff;
    logic             r_valid;
    logic [2*W-1:0]   r_rad;
    logic [W:0]       r_rem;
    logic [W-1:0]     r_root;
    logic [SIDE_BITS-1:0] r_side;

    assign t       = {i_rem, i_rad[2*W-1:2*W-2]};
    assign trial   = {1'b0, i_root, 2'b01};
    assign ge      = t >= trial;
    assign diff    = ge ? t - trial : t;
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rad  <= {i_rad[2*W-3:0], 2'b00};
            r_rem  <= diff[W:0];
            r_root <= {i_root[W-2:0], ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

FILE: hw/rtl/v3a_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_div_cell
// one quotient bit of the normalize divide for all three lanes, restoring
// step against the shared length
// ----------------------------------------------------------------------------
module v3a_div_cell #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = v3a_pkg::DEF_FRAC_BITS,
    parameter int SIDE_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [WORD_BITS-1:0]        i_len,
    input  logic [2:0][WORD_BITS-1:0]   i_rem,
    input  logic [2:0][FRAC_BITS:0]     i_quo,
    input  logic [SIDE_BITS-1:0]        i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [WORD_BITS-1:0]        o_len,
    output logic [2:0][WORD_BITS-1:0]   o_rem,
    output logic [2:0][FRAC_BITS:0]     o_quo,
    output logic [SIDE_BITS-1:0]        o_side
);
    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;

    logic [W:0]           t [3];
    logic [W:0]           d [3];
    logic [2:0]           ge;
    logic [2:0][W-1:0]    n_rem;
    logic [2:0][F:0]      n_quo;
    logic                 r_valid;
    logic [W-1:0]         r_len;
    logic [2:0][W-1:0]    r_rem;
    logic [2:0][F:0]      r_quo;
    logic [SIDE_BITS-1:0] r_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t[i]     = {i_rem[i], 1'b0};
            ge[i]    = t[i] >= {1'b0, i_len};
            d[i]     = ge[i] ? t[i] - {1'b0, i_len} : t[i];
            n_rem[i] = d[i][W-1:0];
            n_quo[i] = {i_quo[i][F-1:0], ge[i]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_len  <= i_len;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

FILE: hw/rtl/v3a_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_back
// result stage: picks the lane values per operation, rounds the products,
// saturates to the word and holds the result until it is taken
// ----------------------------------------------------------------------------
module v3a_back #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = v3a_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_op,
    input  logic [2:0]                    i_neg,
    input  logic [2:0][2*WORD_BITS+2:0]   i_val,
    input  logic [WORD_BITS-1:0]          i_len,
    input  logic [2:0][FRAC_BITS:0]       i_quo,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [WORD_BITS-1:0]          o_x,
    output logic [WORD_BITS-1:0]          o_y,
    output logic [WORD_BITS-1:0]          o_z,
    output logic                          o_ovf,
    output logic                          o_zl
);
    import v3a_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * WORD_BITS + 3;
    localparam logic signed [PW-1:0] C_HALF = PW'(1) << (F - 1);
    localparam logic [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [PW-1:0] x [3];
    logic signed [PW-1:0] y [3];
    logic signed [PW-1:0] m [3];
    logic [2:0]           rnd;
    logic [2:0]           fit;
    logic [W-1:0]         res [3];
    logic                 n_zl;
    logic                 n_ovf;

    logic                 r_valid;
    logic [W-1:0]         r_x;
    logic [W-1:0]         r_y;
    logic [W-1:0]         r_z;
    logic                 r_ovf;
    logic                 r_zl;

    always_comb begin
        n_zl = 1'b0;
        for (int i = 0; i < 3; i++) begin
            x[i]   = '0;
            rnd[i] = 1'b0;
            m[i]   = PW'(i_quo[i]);
        end
        unique case (t_op'(i_op))
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    x[i] = i_val[i];
                end
            end
            OP_DOT: begin
                x[0]   = i_val[0];
                rnd[0] = 1'b1;
            end
            OP_CROSS, OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    x[i]   = i_val[i];
                    rnd[i] = 1'b1;
                end
            end
            OP_LENGTH: begin
                x[0] = PW'(i_len);
            end
            OP_NORM: begin
                if (i_len == '0) begin
                    n_zl = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        x[i] = i_neg[i] ? -m[i] : m[i];
                    end
                end
            end
            default: begin
                n_zl = 1'b0;
            end
        endcase
        n_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            y[i]   = rnd[i] ? (x[i] + C_HALF) >>> F : x[i];
            fit[i] = (&y[i][PW-1:W-1]) || !(|y[i][PW-1:W-1]);
            res[i] = fit[i] ? y[i][W-1:0] : (y[i][PW-1] ? C_MIN : C_MAX);
            n_ovf  = n_ovf || !fit[i];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= res[0];
            r_y   <= res[1];
            r_z   <= res[2];
            r_ovf <= n_ovf;
            r_zl  <= n_zl;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_ovf   = r_ovf;
    assign o_zl    = r_zl;

    a_zl_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_zl |-> r_x == '0 && r_y == '0 && r_z == '0 && !r_ovf)
        else $error("zero length result not cleared");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_ovf |-> r_x == C_MAX || r_x == C_MIN || r_y == C_MAX
            || r_y == C_MIN || r_z == C_MAX || r_z == C_MIN)
        else $error("overflow without a saturated lane");

    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(i_valid && o_ready))
        else $error("result appeared without a transfer in");

endmodule

FILE: hw/rtl/vector3_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_alu
// 3d vector unit: add, sub, dot, cross, scale, length, normalize in signed
// fixed point with rounding and saturation
// ----------------------------------------------------------------------------
// One request enters per cycle and one result leaves per cycle while the
// output is not stalled. The default format is Q16.16. The path holds the
// product and sum registers for the multipliers and sums, a row of WORD_BITS
// square root cells that each form one root bit, a row of FRAC_BITS divide
// cells that each form one quotient bit for all three lanes, and the result
// register. Every request walks the whole row, so results come out in
// request order; a stalled output only holds the cells that are full.
module vector3_alu #(
    parameter int WORD_BITS = v3a_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = v3a_pkg::DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    v3a_req_if.sink   i_req,
    v3a_rsp_if.source o_rsp
);
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * WORD_BITS + 3;
    localparam int SW  = 3 + 3 * WORD_BITS + 3 + 3 * PW;
    localparam int DW  = 3 + 3 + 3 * PW;

    logic              f_valid;
    logic [2:0]        f_op;
    logic [2:0][W-1:0] f_mag;
    logic [2:0]        f_neg;
    logic [2:0][PW-1:0] f_val;

    logic              sq_valid [W+1];
    logic              sq_ready [W+1];
    logic [2*W-1:0]    sq_rad   [W+1];
    logic [W:0]        sq_rem   [W+1];
    logic [W-1:0]      sq_root  [W+1];
    logic [SW-1:0]     sq_side  [W+1];

    logic [2:0]        s_op;
    logic [2:0][W-1:0] s_mag;
    logic [2:0]        s_neg;
    logic [2:0][PW-1:0] s_val;
    logic [W-1:0]      s_len;

    logic              dv_valid [F+1];
    logic              dv_ready [F+1];
    logic [W-1:0]      dv_len   [F+1];
    logic [2:0][W-1:0] dv_rem   [F+1];
    logic [2:0][F:0]   dv_quo   [F+1];
    logic [DW-1:0]     dv_side  [F+1];

    logic [2:0]        e_op;
    logic [2:0]        e_neg;
    logic [2:0][PW-1:0] e_val;
    logic [2:0]        ge0;

    v3a_front #(
        .WORD_BITS (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_op    (i_req.req_type),
        .i_a     ({i_req.a_z, i_req.a_y, i_req.a_x}),
        .i_b     ({i_req.b_z, i_req.b_y, i_req.b_x}),
        .i_s     (i_req.scale_factor),
        .o_valid (f_valid),
        .i_ready (sq_ready[0]),
        .o_op    (f_op),
        .o_mag   (f_mag),
        .o_neg   (f_neg),
        .o_val   (f_val),
        .o_rad   (sq_rad[0])
    );

    assign sq_valid[0] = f_valid;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {f_op, f_mag, f_neg, f_val};

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        v3a_sqrt_cell #(
            .WORD_BITS (W),
            .SIDE_BITS (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid[k]),
            .o_ready (sq_ready[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .i_ready (sq_ready[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    assign {s_op, s_mag, s_neg, s_val} = sq_side[W];
    assign s_len = sq_root[W];

    // top quotient bit, the magnitude never exceeds the length
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ge0[i]       = s_mag[i] >= s_len;
            dv_rem[0][i] = ge0[i] ? s_mag[i] - s_len : s_mag[i];
            dv_quo[0][i] = (F+1)'(ge0[i]);
        end
    end

    assign dv_valid[0]  = sq_valid[W];
    assign sq_ready[W]  = dv_ready[0];
    assign dv_len[0]    = s_len;
    assign dv_side[0]   = {s_op, s_neg, s_val};

    for (genvar k = 0; k < F; k++) begin : g_div
        v3a_div_cell #(
            .WORD_BITS (W),
            .FRAC_BITS (F),
            .SIDE_BITS (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[k]),
            .o_ready (dv_ready[k]),
            .i_len   (dv_len[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_valid[k+1]),
            .i_ready (dv_ready[k+1]),
            .o_len   (dv_len[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    assign {e_op, e_neg, e_val} = dv_side[F];

    v3a_back #(
        .WORD_BITS (W),
        .FRAC_BITS (F)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid[F]),
        .o_ready (dv_ready[F]),
        .i_op    (e_op),
        .i_neg   (e_neg),
        .i_val   (e_val),
        .i_len   (dv_len[F]),
        .i_quo   (dv_quo[F]),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_x     (o_rsp.r_x),
        .o_y     (o_rsp.r_y),
        .o_z     (o_rsp.r_z),
        .o_ovf   (o_rsp.overflow),
        .o_zl    (o_rsp.zero_length)
    );

endmodule
